// ===== hdl/psdt_pkg.sv =====
// Shared types and constants of the priority scheduler with delay table.
`timescale 1ns / 1ps
package psdt_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TASK_W = 4;
  localparam int TIME_W = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 72;

  localparam logic [3:0] MODE_TICK = 4'd0;
  localparam logic [3:0] MODE_DELAY = 4'd1;
  localparam logic [3:0] MODE_DELAY_UNTIL = 4'd2;
  localparam logic [3:0] MODE_SET_ACTIVE = 4'd3;
  localparam logic [3:0] MODE_REQ_SWITCH = 4'd4;
  localparam logic [3:0] MODE_CHECK_SWITCH = 4'd5;
  localparam logic [3:0] MODE_ENTER_CRIT = 4'd6;
  localparam logic [3:0] MODE_LEAVE_CRIT = 4'd7;
  localparam logic [3:0] MODE_START = 4'd8;

  typedef enum logic [3:0] {
    OP_TICK,
    OP_DELAY,
    OP_DELAY_UNTIL,
    OP_SET_ACTIVE,
    OP_REQ_SWITCH,
    OP_CHECK_SWITCH,
    OP_ENTER_CRIT,
    OP_LEAVE_CRIT,
    OP_START,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] delay_amount;
    logic [TIME_W-1:0] base_time;
    logic              active_value;
  } item_t;

  typedef struct packed {
    logic              request_stored;
    logic [TIME_W-1:0] wake_time;
    logic [TIME_W-1:0] tick_value;
    logic [TASK_W-1:0] running_task;
    logic              switch_request;
  } result_t;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] wake;
  } entry_t;

  typedef struct packed {
    logic scanning;
    logic serving;
  } back_status_t;

endpackage

// ===== hdl/psdt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module psdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/psdt_front.sv =====
// Front end: accepts stream transfers and classifies them into queue items.
`timescale 1ns / 1ps
module psdt_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [psdt_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [psdt_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output psdt_pkg::item_t                q_item
);

  psdt_pkg::op_t op;

  always_comb begin
    case (s_tuser)
      psdt_pkg::MODE_TICK:         op = psdt_pkg::OP_TICK;
      psdt_pkg::MODE_DELAY:        op = psdt_pkg::OP_DELAY;
      psdt_pkg::MODE_DELAY_UNTIL:  op = psdt_pkg::OP_DELAY_UNTIL;
      psdt_pkg::MODE_SET_ACTIVE:   op = psdt_pkg::OP_SET_ACTIVE;
      psdt_pkg::MODE_REQ_SWITCH:   op = psdt_pkg::OP_REQ_SWITCH;
      psdt_pkg::MODE_CHECK_SWITCH: op = psdt_pkg::OP_CHECK_SWITCH;
      psdt_pkg::MODE_ENTER_CRIT:   op = psdt_pkg::OP_ENTER_CRIT;
      psdt_pkg::MODE_LEAVE_CRIT:   op = psdt_pkg::OP_LEAVE_CRIT;
      psdt_pkg::MODE_START:        op = psdt_pkg::OP_START;
      default:                     op = psdt_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    q_item.op           = op;
    q_item.task_id      = s_tdata[3:0];
    q_item.delay_amount = s_tdata[35:4];
    q_item.base_time    = s_tdata[67:36];
    q_item.active_value = s_tdata[68];
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

endmodule

// ===== hdl/psdt_queue.sv =====
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps
module psdt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psdt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output psdt_pkg::item_t head_item
);

  localparam int PTR_W = (psdt_pkg::QUEUE_DEPTH > 1) ? $clog2(psdt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(psdt_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(psdt_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(psdt_pkg::QUEUE_DEPTH);

  psdt_pkg::item_t  slots [psdt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == DEPTH_CNT);
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/psdt_back.sv =====
// Back end: scheduler state, delay table scan sequencer and result register.
`timescale 1ns / 1ps
module psdt_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  psdt_pkg::item_t                q_item,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output psdt_pkg::result_t              m_result,
  output psdt_pkg::back_status_t         status
);

  localparam int N = psdt_pkg::MAX_TASKS;
  localparam int IW = psdt_pkg::IDX_W;
  localparam int CW = psdt_pkg::CNT_W;
  localparam int TW = psdt_pkg::TASK_W;
  localparam int MW = psdt_pkg::TIME_W;
  localparam logic [CW-1:0] CNT_END = CW'(N);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SERVE = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [MW-1:0]     tick_count, tick_count_next;
  logic              started, started_next;
  logic              in_critical, in_critical_next;
  logic              switch_pending, switch_pending_next;
  logic [TW-1:0]     cur_task, cur_task_next;
  logic [N-1:0]      active_mask, active_mask_next;
  logic [MW-1:0]     next_deadline, next_deadline_next;
  logic [N-1:0]      valid_bits, valid_bits_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic              rd_pending, rd_pending_next;
  logic [IW-1:0]     rd_idx, rd_idx_next;
  logic [MW-1:0]     fresh, fresh_next;
  logic              out_valid, out_valid_next;
  psdt_pkg::result_t out_data, out_data_next;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [IW-1:0]     ram_raddr;
  psdt_pkg::entry_t  ram_wdata;
  psdt_pkg::entry_t  ram_rdata;

  logic              out_free;
  logic [IW-1:0]     free_idx;
  logic              has_free;
  logic [TW-1:0]     pick;
  logic              pick_any;
  logic              task_ok;
  logic [IW-1:0]     task_idx;
  logic [IW-1:0]     ent_idx;
  logic [MW-1:0]     wake;
  logic [MW-1:0]     tick_inc;
  logic              stored;

  psdt_ram #(
    .WIDTH($bits(psdt_pkg::entry_t)),
    .DEPTH(N)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free = !out_valid || m_tready;
  assign task_ok  = (int'(q_item.task_id) < N);
  assign task_idx = IW'(q_item.task_id);
  assign ent_idx  = IW'(ram_rdata.task_id);
  assign tick_inc = tick_count + MW'(started);

  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_idx = IW'(i);
      end
    end
    has_free = !(&valid_bits);
  end

  always_comb begin
    pick = cur_task;
    for (int i = 0; i < N; i++) begin
      if (active_mask[i]) begin
        pick = TW'(i);
      end
    end
    pick_any = |active_mask;
  end

  always_comb begin
    wake = ((q_item.op == psdt_pkg::OP_DELAY) ? tick_count : q_item.base_time)
           + q_item.delay_amount;
  end

  always_comb begin
    state_next          = state;
    tick_count_next     = tick_count;
    started_next        = started;
    in_critical_next    = in_critical;
    switch_pending_next = switch_pending;
    cur_task_next       = cur_task;
    active_mask_next    = active_mask;
    next_deadline_next  = next_deadline;
    valid_bits_next     = valid_bits;
    cnt_next            = cnt;
    rd_pending_next     = 1'b0;
    rd_idx_next         = rd_idx;
    fresh_next          = fresh;
    out_valid_next      = out_valid && !m_tready;
    out_data_next       = out_data;
    q_pop               = 1'b0;
    ram_we              = 1'b0;
    ram_waddr           = free_idx;
    ram_wdata.task_id   = q_item.task_id;
    ram_wdata.wake      = wake;
    ram_raddr           = cnt[IW-1:0];
    stored              = 1'b0;

    case (state)
      ST_IDLE: begin
        if (q_valid && q_item.op == psdt_pkg::OP_TICK) begin
          q_pop           = 1'b1;
          tick_count_next = tick_inc;
          if (!in_critical && tick_inc >= next_deadline) begin
            state_next = ST_SCAN;
            cnt_next   = '0;
            fresh_next = '1;
          end else begin
            state_next = ST_SERVE;
          end
        end else if (q_valid && out_free) begin
          q_pop                        = 1'b1;
          out_valid_next               = 1'b1;
          out_data_next.switch_request = 1'b0;
          out_data_next.tick_value     = tick_count;
          out_data_next.wake_time      = '0;
          out_data_next.request_stored = 1'b0;
          case (q_item.op)
            psdt_pkg::OP_DELAY, psdt_pkg::OP_DELAY_UNTIL: begin
              stored = task_ok && active_mask[task_idx] && has_free;
              if (stored) begin
                ram_we                     = 1'b1;
                active_mask_next[task_idx] = 1'b0;
                valid_bits_next[free_idx]  = 1'b1;
                if (next_deadline == '0 || wake < next_deadline) begin
                  next_deadline_next = wake;
                end
                switch_pending_next     = 1'b1;
                in_critical_next        = 1'b0;
                out_data_next.wake_time = wake;
              end else if (q_item.op == psdt_pkg::OP_DELAY_UNTIL) begin
                out_data_next.wake_time = q_item.base_time;
              end
              out_data_next.request_stored = stored;
            end
            psdt_pkg::OP_SET_ACTIVE: begin
              if (task_ok) begin
                active_mask_next[task_idx] = q_item.active_value;
              end
            end
            psdt_pkg::OP_REQ_SWITCH: begin
              switch_pending_next = 1'b1;
            end
            psdt_pkg::OP_CHECK_SWITCH: begin
              if (switch_pending) begin
                switch_pending_next = 1'b0;
                if (!in_critical) begin
                  cur_task_next = pick;
                end
                out_data_next.switch_request = 1'b1;
              end
            end
            psdt_pkg::OP_ENTER_CRIT: begin
              in_critical_next = 1'b1;
            end
            psdt_pkg::OP_LEAVE_CRIT: begin
              in_critical_next = 1'b0;
            end
            psdt_pkg::OP_START: begin
              if (task_ok) begin
                cur_task_next = q_item.task_id;
              end
              started_next = 1'b1;
            end
            default: begin
            end
          endcase
          out_data_next.running_task = cur_task_next;
        end
      end

      ST_SCAN: begin
        if (rd_pending && valid_bits[rd_idx]) begin
          if (ram_rdata.wake == next_deadline) begin
            if (int'(ram_rdata.task_id) < N) begin
              active_mask_next[ent_idx] = 1'b1;
            end
            if (ram_rdata.task_id > cur_task) begin
              switch_pending_next = 1'b1;
            end
            valid_bits_next[rd_idx] = 1'b0;
          end else if (ram_rdata.wake < fresh) begin
            fresh_next = ram_rdata.wake;
          end
        end
        if (cnt != CNT_END) begin
          rd_pending_next = 1'b1;
          rd_idx_next     = cnt[IW-1:0];
          cnt_next        = cnt + 1'b1;
        end else if (!rd_pending) begin
          next_deadline_next = fresh;
          state_next         = ST_SERVE;
        end
      end

      ST_SERVE: begin
        if (out_free) begin
          out_valid_next               = 1'b1;
          out_data_next.switch_request = 1'b0;
          out_data_next.tick_value     = tick_count;
          out_data_next.wake_time      = '0;
          out_data_next.request_stored = 1'b0;
          if (!in_critical && switch_pending) begin
            switch_pending_next = 1'b0;
            if (pick_any && pick != cur_task) begin
              cur_task_next                = pick;
              out_data_next.switch_request = 1'b1;
            end
          end
          out_data_next.running_task = cur_task_next;
          state_next                 = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_count     <= '0;
      started        <= 1'b0;
      in_critical    <= 1'b0;
      switch_pending <= 1'b0;
      cur_task       <= '0;
      active_mask    <= '0;
      next_deadline  <= '1;
      valid_bits     <= '0;
      cnt            <= '0;
      rd_pending     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      tick_count     <= tick_count_next;
      started        <= started_next;
      in_critical    <= in_critical_next;
      switch_pending <= switch_pending_next;
      cur_task       <= cur_task_next;
      active_mask    <= active_mask_next;
      next_deadline  <= next_deadline_next;
      valid_bits     <= valid_bits_next;
      cnt            <= cnt_next;
      rd_pending     <= rd_pending_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    fresh    <= fresh_next;
    out_data <= out_data_next;
  end

  assign m_tvalid        = out_valid;
  assign m_result        = out_data;
  assign status.scanning = (state == ST_SCAN);
  assign status.serving  = (state == ST_SERVE);

endmodule

// ===== hdl/priority_scheduler_with_delay_table_core.sv =====
// Top level of the priority scheduler with delay table.
//
// Channel  Direction  Signals                      Contents
// s        in         s_tvalid s_tready s_tdata    one command item, mode in s_tuser
// m        out        m_tvalid m_tready m_tdata    one result item per command
//
// Most commands are served from the queue head in idle once the output is free.
// A tick that reaches the deadline outside a critical section scans the delay
// table one entry per cycle through the table RAM read port; other ticks skip the scan.
// Reset clears the tick count, flags, active mask and table valid bits.
// The input side keeps taking transfers while the queue has room, even while a
// result waits in the output register for m_tready.
`timescale 1ns / 1ps
module priority_scheduler_with_delay_table_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // task_id[3:0], delay_amount[35:4], base_time[67:36], active_value[68], zero fill
  input  logic [psdt_pkg::S_TDATA_W-1:0] s_tdata,
  // mode[3:0]
  input  logic [psdt_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // switch_request[0], running_task[4:1], tick_value[36:5], wake_time[68:37],
  // request_stored[69], zero fill
  output logic [psdt_pkg::M_TDATA_W-1:0] m_tdata
);

  logic                   q_full;
  logic                   q_push;
  psdt_pkg::item_t        q_in;
  logic                   q_pop;
  logic                   q_valid;
  psdt_pkg::item_t        q_head;
  psdt_pkg::result_t      result;
  psdt_pkg::back_status_t back_status;

  psdt_front u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_in)
  );

  psdt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_item (q_head)
  );

  psdt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_result(result),
    .status  (back_status)
  );

  assign m_tdata = psdt_pkg::M_TDATA_W'(result);

  a_stored_no_switch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[69] |-> !m_tdata[0])
    else $error("stored delay result also requests a switch");

  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> q_valid)
    else $error("accepted transfer did not reach the queue");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    back_status.scanning || back_status.serving |-> !q_pop)
    else $error("queue popped while a tick is still in progress");

endmodule
